// ===== rtl/q931_ie_finder_top_macros.svh =====
// ----------------------------------------------------------------------------
// q931_ie_finder_top_macros.svh
// Assertion macros shared by the information element finder RTL.
// ----------------------------------------------------------------------------
`ifndef Q931_IE_FINDER_TOP_MACROS_SVH
`define Q931_IE_FINDER_TOP_MACROS_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define Q931F_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define Q931F_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/q931f_pkg.sv =====
// ----------------------------------------------------------------------------
// q931f_pkg
// Types and constants of the Q.931 information element finder.
// ----------------------------------------------------------------------------
package q931f_pkg;

	localparam logic [10:0] MaxMessageBytes = 11'd1024;

	localparam logic [3:0] ShiftNibble = 4'h9;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_CRLEN = 3'd1,
		PH_CRREF = 3'd2,
		PH_MTYPE = 3'd3,
		PH_IE    = 3'd4,
		PH_LEN   = 3'd5,
		PH_SKIP  = 3'd6
	} phase_t;

	typedef struct packed {
		logic [7:0]  msg_byte;
		logic        first;
		logic [10:0] msg_length;
		logic [7:0]  wanted_ie;
		logic [2:0]  wanted_codeset;
	} item_t;

	typedef struct packed {
		logic       found;
		logic [9:0] position;
		logic       single_octet;
	} result_t;

	// scanner to output stage
	typedef struct packed {
		logic    emit;
		result_t res;
	} scan_out_t;

endpackage

// ===== rtl/q931f_scan.sv =====
// ----------------------------------------------------------------------------
// q931f_scan
// Per-octet message scanner: state registers and next-state logic.
// ----------------------------------------------------------------------------
module q931f_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  q931f_pkg::item_t      item,
	input  logic                  item_valid,
	input  logic                  advance,
	output q931f_pkg::scan_out_t  sout
);

	q931f_pkg::phase_t phase_q, phase_d;
	logic [7:0]  skip_q, skip_d;
	logic [9:0]  idx_q, idx_d;
	logic [10:0] total_q, total_d;
	logic [7:0]  tgt_ie_q, tgt_ie_d;
	logic [2:0]  tgt_cs_q, tgt_cs_d;
	logic [2:0]  act_cs_q, act_cs_d;
	logic [2:0]  lock_cs_q, lock_cs_d;
	logic        pend_q, pend_d;
	logic        decided_q, decided_d;

	logic        cont;
	logic        emit;
	logic        is_shift;
	logic [2:0]  cs_now;
	logic [10:0] len_in;
	logic [10:0] room;
	logic [7:0]  b;
	q931f_pkg::result_t res;

	assign b = item.msg_byte;
	assign room = total_q - {1'b0, idx_q} - 11'd1;

	always_comb begin
		phase_d   = phase_q;
		skip_d    = skip_q;
		idx_d     = idx_q;
		total_d   = total_q;
		tgt_ie_d  = tgt_ie_q;
		tgt_cs_d  = tgt_cs_q;
		act_cs_d  = act_cs_q;
		lock_cs_d = lock_cs_q;
		pend_d    = pend_q;
		decided_d = decided_q;
		cont      = 1'b0;
		emit      = 1'b0;
		res       = '0;
		is_shift  = (b[7:4] == q931f_pkg::ShiftNibble);
		cs_now    = act_cs_q;
		len_in    = item.msg_length;

		if (item.first) begin
			if (len_in == 11'd0)
				len_in = 11'd1;
			if (len_in > q931f_pkg::MaxMessageBytes)
				len_in = q931f_pkg::MaxMessageBytes;
			total_d   = len_in;
			tgt_ie_d  = item.wanted_ie;
			tgt_cs_d  = item.wanted_codeset;
			act_cs_d  = '0;
			lock_cs_d = '0;
			pend_d    = 1'b0;
			skip_d    = '0;
			idx_d     = '0;
			decided_d = 1'b0;
			phase_d   = q931f_pkg::PH_CRLEN;
			cont      = 1'b1;
		end else if (!decided_q) begin
			cont = 1'b1;
			case (phase_q)
				q931f_pkg::PH_CRLEN: begin
					skip_d  = {4'd0, b[3:0]};
					phase_d = (b[3:0] != 4'd0) ? q931f_pkg::PH_CRREF : q931f_pkg::PH_MTYPE;
				end
				q931f_pkg::PH_CRREF: begin
					skip_d = skip_q - 8'd1;
					if (skip_d == 8'd0)
						phase_d = q931f_pkg::PH_MTYPE;
				end
				q931f_pkg::PH_MTYPE: begin
					phase_d = q931f_pkg::PH_IE;
				end
				q931f_pkg::PH_IE: begin
					if (is_shift) begin
						cs_now = b[2:0];
						if (!b[3])
							lock_cs_d = b[2:0];
					end
					act_cs_d = cs_now;
					if (cs_now == tgt_cs_q) begin
						if (b == tgt_ie_q) begin
							if (b[7]) begin
								emit         = 1'b1;
								res.found    = 1'b1;
								res.position = idx_q;
								res.single_octet = 1'b1;
							end else begin
								pend_d = 1'b1;
							end
						end else if (b > tgt_ie_q && !b[7]) begin
							emit = 1'b1;
						end
					end
					if (!b[7])
						phase_d = q931f_pkg::PH_LEN;
					if (!is_shift)
						act_cs_d = lock_cs_d;
				end
				q931f_pkg::PH_LEN: begin
					if (pend_q) begin
						emit = 1'b1;
						if ({3'd0, b} <= room) begin
							res.found    = 1'b1;
							res.position = idx_q;
						end
					end else begin
						skip_d  = b;
						phase_d = (b != 8'd0) ? q931f_pkg::PH_SKIP : q931f_pkg::PH_IE;
					end
				end
				q931f_pkg::PH_SKIP: begin
					skip_d = skip_q - 8'd1;
					if (skip_d == 8'd0)
						phase_d = q931f_pkg::PH_IE;
				end
				default: begin
					cont = 1'b0;
				end
			endcase
		end

		if (cont && !emit) begin
			if (({1'b0, idx_d} + 11'd1) >= total_d)
				emit = 1'b1;
			else
				idx_d = idx_d + 10'd1;
		end

		if (emit) begin
			decided_d = 1'b1;
			phase_d   = q931f_pkg::PH_IDLE;
			pend_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= q931f_pkg::PH_IDLE;
			skip_q    <= '0;
			idx_q     <= '0;
			total_q   <= '0;
			tgt_ie_q  <= '0;
			tgt_cs_q  <= '0;
			act_cs_q  <= '0;
			lock_cs_q <= '0;
			pend_q    <= 1'b0;
			decided_q <= 1'b1;
		end else if (advance) begin
			phase_q   <= phase_d;
			skip_q    <= skip_d;
			idx_q     <= idx_d;
			total_q   <= total_d;
			tgt_ie_q  <= tgt_ie_d;
			tgt_cs_q  <= tgt_cs_d;
			act_cs_q  <= act_cs_d;
			lock_cs_q <= lock_cs_d;
			pend_q    <= pend_d;
			decided_q <= decided_d;
		end
	end

	assign sout.emit = emit && item_valid;
	assign sout.res  = res;

endmodule

// ===== rtl/q931f_oreg.sv =====
// ----------------------------------------------------------------------------
// q931f_oreg
// Result register with valid/ready hold.
// ----------------------------------------------------------------------------
module q931f_oreg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  q931f_pkg::result_t  din,
	output logic                free,
	output logic                res_valid,
	input  logic                res_ready,
	output q931f_pkg::result_t  res
);

	logic               valid_q;
	q931f_pkg::result_t data_q;

	assign free      = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign res       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= din;
	end

endmodule

// ===== rtl/q931_ie_finder_top.sv =====
// A deciding octet's result is valid once it has passed the input register and then the result register.
// Throughput: one octet per cycle unless a decided result is held; the scanner state is updated once per octet.
// An octet that decides waits in the input register while a result is held.
// Reset: asynchronous, active low; scanner idle with no message open.
// ----------------------------------------------------------------------------
// q931_ie_finder_top
// Finds one information element in a Q.931 message presented octet by octet.
// ----------------------------------------------------------------------------
`include "q931_ie_finder_top_macros.svh"

module q931_ie_finder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_ready,
	input  q931f_pkg::item_t    msg,
	output logic                res_valid,
	input  logic                res_ready,
	output q931f_pkg::result_t  res
);

	logic                 s1_valid_q;
	q931f_pkg::item_t     item_s1;
	q931f_pkg::scan_out_t sout;
	logic                 out_free;
	logic                 s1_adv;

	assign s1_adv    = s1_valid_q && (!sout.emit || out_free);
	assign msg_ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (msg_ready) begin
			s1_valid_q <= msg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_ready && msg_valid)
			item_s1 <= msg;
	end

	q931f_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_s1),
		.item_valid (s1_valid_q),
		.advance    (s1_adv),
		.sout       (sout)
	);

	q931f_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_adv && sout.emit),
		.din       (sout.res),
		.free      (out_free),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	`Q931F_ASSERT_NXT(a_emit_loads, s1_adv && sout.emit, res_valid)
	`Q931F_ASSERT_IMP(a_miss_zero, res_valid && !res.found, res.position == 10'd0 && !res.single_octet)
	`Q931F_ASSERT_IMP(a_single_hit, res_valid && res.single_octet, res.found)
	`Q931F_ASSERT_IMP(a_stall_held, !msg_ready, s1_valid_q && sout.emit)

endmodule
